// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the printable string run extractor.
// Needs nothing else; define NO_ASSERTIONS to drop every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

// ===== rtl/core/psre_pkg.sv =====
// Package for the printable string run extractor: word types, config struct,
// register indexes, widths and the printable-byte test. No dependencies.
`default_nettype none

package psre_pkg;

	localparam int OFFSET_BITS = 32;
	localparam int RUN_LIMIT   = 4096;
	localparam int RUN_BITS    = $clog2(RUN_LIMIT + 1);

	localparam int MIN_RUN_W   = 13;
	localparam int MAX_STR_W   = 16;
	localparam int MAX_CHR_W   = 13;
	localparam int LEN_W       = 13;
	localparam int SOFF_W      = 32;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CMP_W       = (RUN_BITS > MIN_RUN_W) ? RUN_BITS : MIN_RUN_W;

	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_FIRST = 8'h20;
	localparam logic [7:0] CHAR_LAST  = 8'h7E;

	localparam logic [RUN_BITS-1:0] RUN_MAX = RUN_BITS'(RUN_LIMIT);

	localparam logic [MIN_RUN_W-1:0] MIN_RUN_RST = MIN_RUN_W'(4);
	localparam logic [MAX_STR_W-1:0] MAX_STR_RST = MAX_STR_W'(4096);
	localparam logic [MAX_CHR_W-1:0] MAX_CHR_RST = MAX_CHR_W'(256);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_RUN_LENGTH   = 2'd0,
		REG_MAX_STRINGS      = 2'd1,
		REG_MAX_STRING_CHARS = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       op;
		logic       first_of_pass;
		logic       last_of_pass;
	} in_word_t;

	typedef struct packed {
		logic [SOFF_W-1:0] string_offset;
		logic [LEN_W-1:0]  string_length;
		logic              is_utf16;
		logic              table_full;
	} out_word_t;

	typedef struct packed {
		logic [MIN_RUN_W-1:0] min_run_length;
		logic [MAX_STR_W-1:0] max_strings;
		logic [MAX_CHR_W-1:0] max_string_chars;
	} cfg_t;

	function automatic logic is_printable(input logic [7:0] v);
		return (v == CHAR_TAB) || (v >= CHAR_FIRST && v <= CHAR_LAST);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/psre_cfg.sv =====
// Configuration registers of the string extractor, written through a plain
// write port. Uses psre_pkg.
`default_nettype none

module psre_cfg
	import psre_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_run_length   <= MIN_RUN_RST;
			cfg_q.max_strings      <= MAX_STR_RST;
			cfg_q.max_string_chars <= MAX_CHR_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MIN_RUN_LENGTH: begin
					cfg_q.min_run_length <= cfg_data[MIN_RUN_W-1:0];
				end
				REG_MAX_STRINGS: begin
					cfg_q.max_strings <= cfg_data[MAX_STR_W-1:0];
				end
				REG_MAX_STRING_CHARS: begin
					cfg_q.max_string_chars <= cfg_data[MAX_CHR_W-1:0];
				end
				default: begin
					// index beyond the register list: dropped
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/psre_scan.sv =====
// Scanner state and per-byte step logic: run tracking for the ASCII and
// UTF-16LE passes and the report decision. Uses psre_pkg, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module psre_scan
	import psre_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     en,
	input  wire in_word_t item,
	input  wire cfg_t     cfg,
	output logic          res_valid,
	output out_word_t     res
);

	logic [OFFSET_BITS-1:0] byte_position_q;
	logic [RUN_BITS-1:0]    run_length_q;
	logic [OFFSET_BITS-1:0] run_start_q;
	logic                   low_byte_pending_q;
	logic [7:0]             pending_low_byte_q;
	logic [MAX_STR_W-1:0]   strings_reported_q;

	logic [OFFSET_BITS-1:0] pos;
	logic [RUN_BITS-1:0]    run_b;
	logic                   pend_b;
	logic [7:0]             plow_b;
	logic [MAX_STR_W-1:0]   cnt_b;

	logic                   grow;
	logic                   flush_mid;
	logic [OFFSET_BITS-1:0] grow_at;
	logic [RUN_BITS-1:0]    run_1;
	logic [OFFSET_BITS-1:0] start_1;
	logic                   pend_1;
	logic [7:0]             plow_1;

	logic [RUN_BITS-1:0]    flush_len;
	logic [CMP_W-1:0]       need;
	logic [CMP_W-1:0]       flush_len_w;
	logic [CMP_W-1:0]       chars_w;
	logic                   report;
	logic [MAX_STR_W-1:0]   cnt_next;

	always_comb begin
		// first byte of a pass starts from a clean slate, but a UTF-16LE pass keeps the string count
		pos    = item.first_of_pass ? '0 : byte_position_q;
		run_b  = item.first_of_pass ? '0 : run_length_q;
		pend_b = item.first_of_pass ? 1'b0 : low_byte_pending_q;
		plow_b = item.first_of_pass ? 8'h00 : pending_low_byte_q;
		cnt_b  = (item.first_of_pass && !item.op) ? '0 : strings_reported_q;

		grow      = 1'b0;
		flush_mid = 1'b0;
		grow_at   = pos;
		pend_1    = pend_b;
		plow_1    = plow_b;

		if (!item.op) begin
			grow      = is_printable(item.byte_value);
			flush_mid = !grow;
		end else if (pend_b) begin
			if (item.byte_value == 8'h00 && is_printable(plow_b)) begin
				grow    = 1'b1;
				grow_at = pos - OFFSET_BITS'(1);
				pend_1  = 1'b0;
			end else begin
				// failed pair: restart pairing at this byte
				flush_mid = 1'b1;
				plow_1    = item.byte_value;
				pend_1    = 1'b1;
			end
		end else begin
			plow_1 = item.byte_value;
			pend_1 = 1'b1;
		end

		start_1 = (grow && run_b == '0) ? grow_at : run_start_q;
		if (grow) begin
			run_1 = (run_b < RUN_MAX) ? run_b + RUN_BITS'(1) : run_b;
		end else if (flush_mid) begin
			run_1 = '0;
		end else begin
			run_1 = run_b;
		end

		// a flush mid-byte empties the run, so end-of-pass then finds nothing
		flush_len   = flush_mid ? run_b : run_1;
		need        = (cfg.min_run_length == '0) ? CMP_W'(1) : CMP_W'(cfg.min_run_length);
		flush_len_w = CMP_W'(flush_len);
		chars_w     = CMP_W'(cfg.max_string_chars);
		report      = (flush_mid || item.last_of_pass) && flush_len != '0
		              && flush_len_w >= need && cnt_b < cfg.max_strings;
		cnt_next    = cnt_b + MAX_STR_W'(1);

		res_valid         = report;
		res.string_offset = SOFF_W'(start_1);
		res.string_length = LEN_W'((flush_len_w < chars_w) ? flush_len_w : chars_w);
		res.is_utf16      = item.op;
		res.table_full    = (cnt_next == cfg.max_strings);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q    <= '0;
			run_length_q       <= '0;
			run_start_q        <= '0;
			low_byte_pending_q <= 1'b0;
			pending_low_byte_q <= 8'h00;
			strings_reported_q <= '0;
		end else if (en) begin
			byte_position_q    <= pos + OFFSET_BITS'(1);
			run_length_q       <= item.last_of_pass ? '0 : run_1;
			run_start_q        <= start_1;
			low_byte_pending_q <= item.last_of_pass ? 1'b0 : pend_1;
			pending_low_byte_q <= plow_1;
			strings_reported_q <= report ? cnt_next : cnt_b;
		end
	end

	`ASSERT_PROP(a_count_after_report, clk, arst_n, en && res_valid |=> strings_reported_q != '0)
	`ASSERT_NEVER(a_run_saturates, clk, arst_n, run_length_q > RUN_MAX)
	`ASSERT_PROP(a_last_clears, clk, arst_n, en && item.last_of_pass |=> run_length_q == '0 && !low_byte_pending_q)
	`ASSERT_NEVER(a_report_empty, clk, arst_n, en && res_valid && res.string_length == '0 && cfg.max_string_chars != '0)

endmodule

`default_nettype wire

// ===== rtl/core/psre_out_reg.sv =====
// Result register of the string extractor: holds one report word until the
// consumer takes it. Uses psre_pkg.
`default_nettype none

module psre_out_reg
	import psre_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      load,
	input  wire logic      load_valid,
	input  wire out_word_t load_word,
	output logic           ready,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_word_t      out_word
);

	logic      valid_q;
	out_word_t word_q;

	assign ready = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= load && load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && load && load_valid) begin
			word_q <= load_word;
		end
	end

	assign out_valid = valid_q;
	assign out_word  = word_q;

endmodule

`default_nettype wire

// ===== rtl/core/printable_string_run_extractor_top.sv =====
// Top level of the printable string run extractor: input register, config
// registers, scanner and result register. Uses psre_pkg and the psre_ modules.
`default_nettype none

// Takes one file byte per clock and reports runs of printable characters in
// an ASCII pass (op 0) or a UTF-16LE pass (op 1). A byte is registered on
// accept, stepped through the scanner once the result register can take its
// report, and its report, if any, is then loaded into the result register
// and offered from there. One byte per cycle is sustained while no report is
// held back. The input register frees up whenever the result register is
// empty or being taken, so the only thing that throttles input is out_stall
// held high with a report waiting. Write the configuration registers only
// while no byte is in flight.
module printable_string_run_extractor_top
	import psre_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire in_word_t              in_word,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output out_word_t                  out_word,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic      valid_s1;
	in_word_t  word_s1;
	logic      out_ready;
	logic      advance;
	logic      res_valid;
	out_word_t res;
	cfg_t      cfg;

	// the s1 word steps the scanner only when its result has somewhere to go
	assign advance  = valid_s1 && out_ready;
	assign in_stall = valid_s1 && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			word_s1 <= in_word;
		end
	end

	psre_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	psre_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.item      (word_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	psre_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (advance),
		.load_valid (res_valid),
		.load_word  (res),
		.ready      (out_ready),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_word   (out_word)
	);

endmodule

`default_nettype wire
